/* rtl/langtons_ant_step_top_defines.svh */
// Assertion macros for the Langton's ant step block.
`ifndef LANGTONS_ANT_STEP_TOP_DEFINES_SVH
`define LANGTONS_ANT_STEP_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LANT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LANT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lant_pkg.sv */
// Types, codes and helpers shared by the Langton's ant step block.
package lant_pkg;

    localparam int POS_W   = 6;
    localparam int EXT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [EXT_W-1:0] EXT_LIMIT = 7'd64;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [1:0] MODE_STEP  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_PLACE = 2'd3;

    localparam logic [1:0] HEAD_N = 2'd0;
    localparam logic [1:0] HEAD_E = 2'd1;
    localparam logic [1:0] HEAD_S = 2'd2;
    localparam logic [1:0] HEAD_W = 2'd3;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_heading;

    // controller -> datapath
    typedef struct packed {
        logic clr;     // clearing sweep writes one cell
        logic accept;  // latch item, issue grid read
        logic exec;    // finish item, write grid, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_stall;
    } t_status;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v,
                                                      input logic [EXT_W-1:0] lim);
        logic [EXT_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/lant_in_if.sv */
// Input channel: command word of the Langton's ant block.
interface lant_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [5:0]               row_addr;
    logic [5:0]               col_addr;
    logic                     cell_in;
    logic [1:0]               heading_in;

    modport source (
        output valid, mode, row_addr, col_addr, cell_in, heading_in,
        input  ready
    );
    modport sink (
        input  valid, mode, row_addr, col_addr, cell_in, heading_in,
        output ready
    );
endinterface

/* rtl/lant_out_if.sv */
// Output channel: result word of the Langton's ant block.
interface lant_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] ant_row;
    logic [5:0] ant_col;
    logic [1:0] ant_heading;
    logic       cell_out;
    logic       addr_error;

    modport source (
        output valid, ant_row, ant_col, ant_heading, cell_out, addr_error,
        input  ready
    );
    modport sink (
        input  valid, ant_row, ant_col, ant_heading, cell_out, addr_error,
        output ready
    );
endinterface

/* rtl/lant_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module lant_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lant_ctrl.sv */
// Controller: clearing sweep after reset, then accept / execute per word.
module lant_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lant_pkg::t_status i_status,
    output lant_pkg::t_cmd    o_cmd
);
    import lant_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new word
                if (!i_status.out_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end
endmodule

/* rtl/lant_dp.sv */
// Datapath: config registers, ant state, grid memory and result register.
module lant_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lant_pkg::t_cmd                    i_cmd,
    output lant_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [lant_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lant_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [1:0]                        i_mode,
    input  logic [5:0]                        i_row_addr,
    input  logic [5:0]                        i_col_addr,
    input  logic                              i_cell_in,
    input  logic [1:0]                        i_heading_in,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [5:0]                        o_ant_row,
    output logic [5:0]                        o_ant_col,
    output logic [1:0]                        o_ant_heading,
    output logic                              o_cell_out,
    output logic                              o_addr_error
);
    import lant_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_LIM_I = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COL_LIM_I = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam logic [EXT_W-1:0] ROW_LIM = EXT_W'(ROW_LIM_I);
    localparam logic [EXT_W-1:0] COL_LIM = EXT_W'(COL_LIM_I);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [CFG_W-1:0]  r_rows_in_use;
    logic [CFG_W-1:0]  r_cols_in_use;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [POS_W-1:0]  r_pos_row;
    logic [POS_W-1:0]  r_pos_col;
    t_heading          r_heading;
    logic [POS_W-1:0]  n_pos_row;
    logic [POS_W-1:0]  n_pos_col;
    t_heading          n_heading;

    t_mode             r_mode;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic              r_cin;
    t_heading          r_hin;
    logic              r_err;
    logic [ADDR_W-1:0] r_addr;

    logic              r_out_valid;
    logic [5:0]        r_ant_row;
    logic [5:0]        r_ant_col;
    logic [1:0]        r_ant_heading;
    logic              r_cell_out;
    logic              r_addr_error;

    logic [EXT_W-1:0]  nr;
    logic [EXT_W-1:0]  nc;
    logic              err_now;
    logic [POS_W-1:0]  acc_row;
    logic [POS_W-1:0]  acc_col;
    logic [ADDR_W-1:0] acc_addr;
    logic              cur;
    t_heading          turn;
    logic              cell_res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [POS_W-1:0]  row_up;
    logic [POS_W-1:0]  row_dn;
    logic [POS_W-1:0]  col_rt;
    logic [POS_W-1:0]  col_lt;

    assign nr = clamp_extent(r_rows_in_use, ROW_LIM);
    assign nc = clamp_extent(r_cols_in_use, COL_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_RESET;
            r_cols_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS: r_rows_in_use <= i_cfg_data;
                CFG_COLS: r_cols_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == LAST_ADDR);
    assign o_status.out_stall = r_out_valid & ~i_out_ready;

    // accept side: pick the cell to read and check the address
    always_comb begin
        if (i_mode == MODE_STEP) begin
            acc_row = r_pos_row;
            acc_col = r_pos_col;
        end else begin
            acc_row = i_row_addr;
            acc_col = i_col_addr;
        end
        err_now  = ({1'b0, acc_row} >= nr) || ({1'b0, acc_col} >= nc);
        acc_addr = ADDR_W'(int'(acc_row) * MAX_COLS + int'(acc_col));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_row  <= i_row_addr;
            r_col  <= i_col_addr;
            r_cin  <= i_cell_in;
            r_hin  <= i_heading_in;
            r_err  <= err_now;
            r_addr <= acc_addr;
        end
    end

    // keep reading the held cell while the result waits
    assign ram_raddr = i_cmd.accept ? acc_addr : r_addr;

    lant_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (cur)
    );

    // execute side
    assign turn   = cur ? (r_heading + 2'd1) : (r_heading + 2'd3);
    assign row_up = (r_pos_row == '0) ? POS_W'(nr - 7'd1) : (r_pos_row - 1'b1);
    assign row_dn = ((EXT_W'(r_pos_row) + 7'd1) >= nr) ? '0 : (r_pos_row + 1'b1);
    assign col_rt = ((EXT_W'(r_pos_col) + 7'd1) >= nc) ? '0 : (r_pos_col + 1'b1);
    assign col_lt = (r_pos_col == '0) ? POS_W'(nc - 7'd1) : (r_pos_col - 1'b1);

    always_comb begin
        n_pos_row = r_pos_row;
        n_pos_col = r_pos_col;
        n_heading = r_heading;
        cell_res  = 1'b0;
        if (!r_err) begin
            case (r_mode)
                MODE_STEP: begin
                    cell_res  = ~cur;
                    n_heading = turn;
                    case (turn)
                        HEAD_N:  n_pos_row = row_up;
                        HEAD_E:  n_pos_col = col_rt;
                        HEAD_S:  n_pos_row = row_dn;
                        default: n_pos_col = col_lt;
                    endcase
                end
                MODE_WRITE: cell_res = r_cin;
                MODE_READ:  cell_res = cur;
                default: begin
                    n_pos_row = r_row;
                    n_pos_col = r_col;
                    n_heading = r_hin;
                    cell_res  = cur;
                end
            endcase
        end
    end

    always_comb begin
        if (i_cmd.clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = i_cmd.exec & ~r_err &
                        ((r_mode == MODE_STEP) | (r_mode == MODE_WRITE));
            ram_waddr = r_addr;
            ram_wdata = cell_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_row <= '0;
            r_pos_col <= '0;
            r_heading <= HEAD_N;
        end else if (i_cmd.exec) begin
            r_pos_row <= n_pos_row;
            r_pos_col <= n_pos_col;
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ant_row     <= n_pos_row;
            r_ant_col     <= n_pos_col;
            r_ant_heading <= n_heading;
            r_cell_out    <= cell_res;
            r_addr_error  <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ant_row     = r_ant_row;
    assign o_ant_col     = r_ant_col;
    assign o_ant_heading = r_ant_heading;
    assign o_cell_out    = r_cell_out;
    assign o_addr_error  = r_addr_error;
endmodule

/* rtl/langtons_ant_step_top.sv */
// Langton's ant step block: top level with controller, datapath and checks.
// Each command word passes from acceptance to a loaded result in order: the
// accept step reads the grid cell (registered read of the 1-bit grid RAM), and
// the execute step, held while the previous result waits for the sink, writes
// it back and updates the ant. The next word is taken once the current one has
// moved into the result register. After reset the grid is cleared by a sweep
// of all MAX_ROWS*MAX_COLS cells (4096 at the defaults), one cell per cycle; no
// word is accepted during the sweep, configuration writes are taken throughout.
`include "langtons_ant_step_top_defines.svh"

module langtons_ant_step_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lant_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lant_pkg::CFG_W-1:0]     i_cfg_data,
    lant_in_if.sink                        i_in,
    lant_out_if.source                     o_out
);
    import lant_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    lant_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lant_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_in.mode),
        .i_row_addr    (i_in.row_addr),
        .i_col_addr    (i_in.col_addr),
        .i_cell_in     (i_in.cell_in),
        .i_heading_in  (i_in.heading_in),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_ant_row     (o_out.ant_row),
        .o_ant_col     (o_out.ant_col),
        .o_ant_heading (o_out.ant_heading),
        .o_cell_out    (o_out.cell_out),
        .o_addr_error  (o_out.addr_error)
    );

    assign i_in.ready = in_ready;

    // one word in flight: no second accept right after one
    `LANT_ASSERT_NEXT(a_one_in_flight, i_in.valid && in_ready, !in_ready, "word accepted while busy")
    // a finished word always shows up at the output
    `LANT_ASSERT_NEXT(a_exec_loads_out, cmd.exec, o_out.valid, "result not presented")
    // nothing accepted during the clearing sweep
    `LANT_ASSERT_NOW(a_no_accept_clr, cmd.clr, !in_ready && !cmd.exec, "accept during grid clear")
endmodule
